### rtl/footswitch_tap_tempo_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the foot switch tap tempo controller
// Immediate-style wrappers around concurrent properties; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FOOTSWITCH_TAP_TEMPO_CONTROLLER_MACROS_SVH
`define FOOTSWITCH_TAP_TEMPO_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds on the same edge
`define FTT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// antecedent holds -> consequent holds on the next edge
`define FTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FTT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define FTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/ftt_pkg.sv
// ----------------------------------------------------------------------------
// Foot switch tap tempo controller package
// Register map, mode codes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ftt_pkg;

	localparam int COUNT_WIDTH_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TAP_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TAP_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_ENABLE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TUNER_ENABLE  = 3'd5;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_TAP    = 2'd1;
	localparam logic [1:0] MODE_TUNER  = 2'd2;

	localparam logic [15:0] SHORT_TICKS_RST   = 16'd8;
	localparam logic [14:0] LONG_TICKS_RST    = 15'd64;
	localparam logic [15:0] MIN_TAP_TICKS_RST = 16'd33;
	localparam logic [15:0] MAX_TAP_TICKS_RST = 16'd1000;

	typedef struct packed {
		logic [15:0] short_ticks;
		logic [14:0] long_ticks;
		logic [15:0] min_tap_ticks;
		logic [15:0] max_tap_ticks;
		logic        tap_enable;
		logic        tuner_enable;
	} ftt_cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] tap_ticks;
		logic        bypass_toggle;
		logic        mute_pulse;
	} ftt_result_t;

endpackage

`default_nettype wire

### rtl/ftt_in_if.sv
// ----------------------------------------------------------------------------
// Tick input channel
// Valid/ready channel carrying the foot switch level of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftt_in_if;
	logic valid;
	logic ready;
	logic switch_pressed;

	modport source (output valid, output switch_pressed, input ready);
	modport sink (input valid, input switch_pressed, output ready);
endinterface

`default_nettype wire

### rtl/ftt_out_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying the mode, tap interval and event pulses.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] tap_ticks;
	logic        bypass_toggle;
	logic        mute_pulse;

	modport source (output valid, output mode, output tap_ticks, output bypass_toggle,
		output mute_pulse, input ready);
	modport sink (input valid, input mode, input tap_ticks, input bypass_toggle,
		input mute_pulse, output ready);
endinterface

`default_nettype wire

### rtl/footswitch_tap_tempo_controller.sv
// ----------------------------------------------------------------------------
// Foot switch tap tempo controller
// Hold/press timing, tap interval capture and mode control per tick.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one transaction per audio tick carrying the foot switch level.
//   result : one transaction per tick with the mode after that tick, the
//            accepted tap interval and the bypass toggle and mute pulses.
//   wr_en / wr_index / wr_data : register writes, taken on any edge with
//            wr_en high; write only while no tick is in flight.
// An accepted tick loads the input register; from there the result register
// is loaded with the updated state's output and raises result valid once it
// is empty or being drained.
// Throughput is one tick per cycle; the input register feeds the result
// register whenever that register is empty or being drained.
// Reset clears the mode to normal, all counters and the tap interval, and
// loads the register reset values. When the receiver stalls, the result
// register holds, the input register fills, and tick.ready drops only once
// both are occupied.
// ----------------------------------------------------------------------------
`default_nettype none
`include "footswitch_tap_tempo_controller_macros.svh"

module footswitch_tap_tempo_controller
	import ftt_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	ftt_in_if.sink                     tick,
	ftt_out_if.source                  result,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	ftt_cfg_t               cfg_q;
	logic                   valid_s1;
	logic                   pressed_s1;
	logic                   valid_s2;
	ftt_result_t            res_s2;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [1:0]             mode_q;
	logic [COUNT_WIDTH-1:0] capt_q;
	logic [15:0]            tap_q;

	logic [COUNT_WIDTH-1:0] hold_nxt;
	logic [COUNT_WIDTH-1:0] tick_nxt;
	logic [1:0]             mode_nxt;
	logic [COUNT_WIDTH-1:0] capt_nxt;
	logic [15:0]            tap_nxt;
	ftt_result_t            res_nxt;
	logic                   adv_s1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_ticks   <= SHORT_TICKS_RST;
			cfg_q.long_ticks    <= LONG_TICKS_RST;
			cfg_q.min_tap_ticks <= MIN_TAP_TICKS_RST;
			cfg_q.max_tap_ticks <= MAX_TAP_TICKS_RST;
			cfg_q.tap_enable    <= 1'b1;
			cfg_q.tuner_enable  <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SHORT_TICKS:   cfg_q.short_ticks   <= wr_data;
				REG_LONG_TICKS:    cfg_q.long_ticks    <= wr_data[14:0];
				REG_MIN_TAP_TICKS: cfg_q.min_tap_ticks <= wr_data;
				REG_MAX_TAP_TICKS: cfg_q.max_tap_ticks <= wr_data;
				REG_TAP_ENABLE:    cfg_q.tap_enable    <= wr_data[0];
				REG_TUNER_ENABLE:  cfg_q.tuner_enable  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// advance stage 1 into the result register when that is free or draining
	assign adv_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			pressed_s1 <= tick.switch_pressed;
		end
	end

	ftt_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.cfg      (cfg_q),
		.pressed  (pressed_s1),
		.hold_cur (hold_q),
		.tick_cur (tick_q),
		.mode_cur (mode_q),
		.capt_cur (capt_q),
		.tap_cur  (tap_q),
		.hold_nxt (hold_nxt),
		.tick_nxt (tick_nxt),
		.mode_nxt (mode_nxt),
		.capt_nxt (capt_nxt),
		.tap_nxt  (tap_nxt),
		.res      (res_nxt)
	);

	// commit state once per tick, as it moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= '0;
			tick_q   <= '0;
			mode_q   <= MODE_NORMAL;
			capt_q   <= '0;
			tap_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				hold_q <= hold_nxt;
				tick_q <= tick_nxt;
				mode_q <= mode_nxt;
				capt_q <= capt_nxt;
				tap_q  <= tap_nxt;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid         = valid_s2;
	assign result.mode          = res_s2.mode;
	assign result.tap_ticks     = res_s2.tap_ticks;
	assign result.bypass_toggle = res_s2.bypass_toggle;
	assign result.mute_pulse    = res_s2.mute_pulse;

	`FTT_ASSERT_SAME(a_mute_in_tuner, clk, arst_n, valid_s2 && res_s2.mute_pulse, res_s2.mode == MODE_TUNER)
	`FTT_ASSERT_SAME(a_bypass_in_normal, clk, arst_n, valid_s2 && res_s2.bypass_toggle, res_s2.mode == MODE_NORMAL)
	`FTT_ASSERT_SAME(a_normal_no_tap, clk, arst_n, mode_q == MODE_NORMAL, tap_q == 16'd0)
	`FTT_ASSERT_NEXT(a_state_commit, clk, arst_n, adv_s1, mode_q == res_s2.mode && tap_q == res_s2.tap_ticks)

endmodule

`default_nettype wire

### rtl/ftt_step.sv
// ----------------------------------------------------------------------------
// Tap tempo next-state logic
// Works out the controller state and the result for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ftt_step
	import ftt_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire ftt_cfg_t               cfg,
	input  wire logic                   pressed,
	input  wire logic [COUNT_WIDTH-1:0] hold_cur,
	input  wire logic [COUNT_WIDTH-1:0] tick_cur,
	input  wire logic [1:0]             mode_cur,
	input  wire logic [COUNT_WIDTH-1:0] capt_cur,
	input  wire logic [15:0]            tap_cur,
	output logic      [COUNT_WIDTH-1:0] hold_nxt,
	output logic      [COUNT_WIDTH-1:0] tick_nxt,
	output logic      [1:0]             mode_nxt,
	output logic      [COUNT_WIDTH-1:0] capt_nxt,
	output logic      [15:0]            tap_nxt,
	output ftt_result_t                 res
);

	localparam int CMP_W = (COUNT_WIDTH > 17) ? COUNT_WIDTH : 17;
	localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] hold_inc;
	logic [16:0]            triple17;
	logic [CMP_W-1:0]       hold_inc_x;
	logic [CMP_W-1:0]       hold_x;
	logic [CMP_W-1:0]       short_x;
	logic [CMP_W-1:0]       long_x;
	logic [CMP_W-1:0]       triple_x;
	logic [CMP_W-1:0]       capt_x;
	logic [CMP_W-1:0]       min_x;
	logic [CMP_W-1:0]       max_x;
	logic                   bypass;
	logic                   mute;

	assign hold_inc   = hold_cur + COUNT_WIDTH'(1);
	assign triple17   = {1'b0, cfg.long_ticks, 1'b0} + {2'b00, cfg.long_ticks};
	assign hold_inc_x = CMP_W'(hold_inc);
	assign hold_x     = CMP_W'(hold_cur);
	assign short_x    = CMP_W'(cfg.short_ticks);
	assign long_x     = CMP_W'(cfg.long_ticks);
	assign triple_x   = CMP_W'(triple17);
	assign capt_x     = CMP_W'(capt_cur);
	assign min_x      = CMP_W'(cfg.min_tap_ticks);
	assign max_x      = CMP_W'(cfg.max_tap_ticks);

	always_comb begin
		tick_nxt = (tick_cur != CMAX) ? tick_cur + COUNT_WIDTH'(1) : tick_cur;
		hold_nxt = hold_cur;
		mode_nxt = mode_cur;
		capt_nxt = capt_cur;
		tap_nxt  = tap_cur;
		bypass   = 1'b0;
		mute     = 1'b0;
		if (pressed) begin
			// a saturated hold counter fires no threshold again
			if (hold_cur != CMAX) begin
				hold_nxt = hold_inc;
				if (mode_cur == MODE_TAP && hold_inc_x == short_x) begin
					capt_nxt = tick_nxt;
					tick_nxt = '0;
				end
				if (hold_inc_x == long_x) begin
					if (mode_cur == MODE_NORMAL) begin
						if (cfg.tap_enable) begin
							mode_nxt = MODE_TAP;
							tick_nxt = '0;
						end
					end else begin
						mode_nxt = MODE_NORMAL;
						tap_nxt  = '0;
					end
				end
				if (hold_inc_x == triple_x && mode_nxt == MODE_TAP && cfg.tuner_enable) begin
					mode_nxt = MODE_TUNER;
					mute     = 1'b1;
				end
			end
		end else begin
			if (hold_x >= short_x && hold_x < long_x) begin
				if (mode_cur == MODE_NORMAL) begin
					bypass = 1'b1;
				end else if (mode_cur == MODE_TAP) begin
					tap_nxt = (min_x < capt_x && capt_x < max_x) ? 16'(capt_cur) : 16'd0;
				end
			end
			hold_nxt = '0;
		end
	end

	always_comb begin
		res.mode          = mode_nxt;
		res.tap_ticks     = tap_nxt;
		res.bypass_toggle = bypass;
		res.mute_pulse    = mute;
	end

endmodule

`default_nettype wire
